@@ sv/bma_pkg.sv @@
// Shared types and constants of the buddy allocator.
package bma_pkg;
	localparam int MaxOrder = 6;
	localparam int Levels = MaxOrder + 1;
	localparam int Slots = 1 << MaxOrder;
	localparam int SlotBits = MaxOrder;
	localparam int CntBits = MaxOrder + 1;
	localparam int OrdBits = $clog2(Levels + 1);
	localparam int IdBits = 16;
	localparam logic [4:0] Log2Cap = 5'd20;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_NO_MEM = 2'd2,
		ST_NO_ID = 2'd3
	} status_t;

	localparam logic [0:0] REG_TOTAL = 1'b0;
	localparam logic [0:0] REG_MIN = 1'b1;
endpackage

@@ sv/buddy_memory_allocator.sv @@
// Top level of the buddy allocator: sequencer, free lists and live table.
// An allocate of a zero size goes to the finish with a bad-size status; else it sizes the
// request by powers of two, searches the orders, splits blocks, takes one and finishes.
// A free looks up and compacts the live table, then scans the free list of each order climbed
// for the buddy while merging, then pushes and finishes. One item at a time: in_stall is high
// from acceptance until the result is loaded. Reset or a config write rebuilds the pool:
// one free top block, no live blocks.
module buddy_memory_allocator import bma_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [23:0] request_size,
	input  logic [15:0] block_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] granted_id,
	output logic [19:0] block_address,
	output logic [20:0] block_size,
	output logic [19:0] internal_waste
);
	typedef enum logic [3:0] {
		S_IDLE, S_SIZE, S_FIND, S_SPLIT, S_TAKE, S_LSCAN, S_LSHIFT,
		S_MSCAN, S_MSHIFT, S_PUSH, S_DONE
	} state_t;

	// Free lists: one memory of Levels*Slots entries, flat index {ord,slot}.
	logic [SlotBits-1:0] fl_mem [Levels*Slots];
	logic [CntBits-1:0]  cnt_q [Levels];
	// Live table: memory plus count.
	logic [IdBits+SlotBits+OrdBits-1:0] lt_mem [Slots];
	logic [CntBits-1:0] live_cnt_q;

	state_t state_q;
	logic [4:0] unit_q, top_q, tcfg_q, mcfg_q;
	logic [IdBits-1:0] next_id_q, bid_q;
	logic [23:0] req_q;
	logic [4:0] p_q;
	logic [OrdBits-1:0] ord_q, k_q;
	logic [SlotBits-1:0] off_q;
	logic [CntBits-1:0] j_q;
	logic rd_pend_q;
	logic [SlotBits-1:0] fl_rd_q;
	logic [IdBits+SlotBits+OrdBits-1:0] lt_rd_q;
	logic [1:0] status_q;
	logic [15:0] gid_q;
	logic [19:0] addr_q, waste_q;
	logic [20:0] size_q;
	logic out_valid_q;
	logic init_q;
	logic op_q;
	logic half_q; // second push of a split
	// Result register: holds a finished item while the sequencer moves on.
	logic [1:0] res_status_q;
	logic [15:0] res_id_q;
	logic [19:0] res_addr_q, res_waste_q;
	logic [20:0] res_size_q;

	function automatic logic [SlotBits+OrdBits-1:0] fl_idx(
			input logic [OrdBits-1:0] o, input logic [CntBits-1:0] s);
		return {o, s[SlotBits-1:0]};
	endfunction

	// Pool geometry from the saturated registers.
	logic [4:0] t_sat, m_sat, u_w, d_w, top_w;
	always_comb begin
		t_sat = (tcfg_q > Log2Cap) ? Log2Cap : tcfg_q;
		m_sat = (mcfg_q > Log2Cap) ? Log2Cap : mcfg_q;
		u_w = (t_sat < m_sat) ? t_sat : m_sat;
		d_w = t_sat - u_w;
		top_w = (d_w > 5'(MaxOrder)) ? 5'(MaxOrder) : d_w;
	end

	// Finish an item once the result register is free or being taken.
	logic done_fire;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign in_stall = (state_q != S_IDLE) || init_q;
	assign out_valid = out_valid_q;
	assign status = res_status_q;
	assign granted_id = res_id_q;
	assign block_address = res_addr_q;
	assign block_size = res_size_q;
	assign internal_waste = res_waste_q;

	logic [OrdBits-1:0] top_o;
	assign top_o = top_q[OrdBits-1:0];
	logic [25:0] bsz;
	assign bsz = 26'd1 << (5'(ord_q) + unit_q);

	// Memory writes.
	logic fl_we; logic [SlotBits+OrdBits-1:0] fl_wa; logic [SlotBits-1:0] fl_wd;
	logic [SlotBits+OrdBits-1:0] fl_ra;
	logic lt_we; logic [SlotBits-1:0] lt_wa, lt_ra; logic [IdBits+SlotBits+OrdBits-1:0] lt_wd;

	always_ff @(posedge clk) begin
		if (fl_we) fl_mem[fl_wa] <= fl_wd;
		fl_rd_q <= fl_mem[fl_ra];
		if (lt_we) lt_mem[lt_wa] <= lt_wd;
		lt_rd_q <= lt_mem[lt_ra];
	end

	logic [IdBits-1:0] lt_id; logic [SlotBits-1:0] lt_off; logic [OrdBits-1:0] lt_ord;
	assign {lt_id, lt_off, lt_ord} = lt_rd_q;
	logic [SlotBits-1:0] buddy;
	assign buddy = off_q ^ SlotBits'(1 << ord_q);

	// Read address and write selection.
	always_comb begin
		fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
		lt_we = 1'b0; lt_wa = '0; lt_wd = '0; lt_ra = j_q[SlotBits-1:0];
		case (state_q)
			S_IDLE: begin
				// seed the top list with the whole pool at offset 0
				if (init_q && !cfg_we) begin
					fl_we = 1'b1; fl_wa = fl_idx(top_w[OrdBits-1:0], '0); fl_wd = '0;
				end
			end
			S_SPLIT: begin
				fl_ra = fl_idx(k_q, cnt_q[k_q] - 1'b1);
				if (rd_pend_q && cnt_q[k_q - 1'b1] != CntBits'(Slots)) begin
					// top of list k: write lower half, upper half next cycle
					fl_we = 1'b1;
					fl_wa = fl_idx(k_q - 1'b1, cnt_q[k_q - 1'b1]);
					fl_wd = fl_rd_q;
				end
			end
			S_TAKE: fl_ra = fl_idx(ord_q, cnt_q[ord_q] - 1'b1);
			S_LSCAN: lt_ra = j_q[SlotBits-1:0];
			S_LSHIFT: begin
				lt_ra = SlotBits'(j_q + 1'b1);
				if (rd_pend_q) begin
					lt_we = 1'b1; lt_wa = j_q[SlotBits-1:0]; lt_wd = lt_rd_q;
				end
			end
			S_MSCAN: fl_ra = fl_idx(ord_q, j_q);
			S_MSHIFT: begin
				fl_ra = fl_idx(ord_q, j_q + 1'b1);
				if (rd_pend_q) begin
					fl_we = 1'b1; fl_wa = fl_idx(ord_q, j_q); fl_wd = fl_rd_q;
				end
			end
			S_PUSH: begin
				if (cnt_q[ord_q] != CntBits'(Slots)) begin
					fl_we = 1'b1; fl_wa = fl_idx(ord_q, cnt_q[ord_q]); fl_wd = off_q;
				end
			end
			S_DONE: begin
				if (done_fire && status_q == ST_OK && !op_q) begin
					lt_we = 1'b1; lt_wa = live_cnt_q[SlotBits-1:0];
					lt_wd = {gid_q, off_q, ord_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tcfg_q <= 5'd10; mcfg_q <= 5'd6;
			init_q <= 1'b1;
			out_valid_q <= 1'b0;
			live_cnt_q <= '0; next_id_q <= '0;
			for (int i = 0; i < Levels; i++) cnt_q[i] <= '0;
			rd_pend_q <= 1'b0; half_q <= 1'b0;
			unit_q <= '0; top_q <= '0;
			res_status_q <= '0; res_id_q <= '0; res_addr_q <= '0;
			res_size_q <= '0; res_waste_q <= '0;
		end else begin
			if (done_fire) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_we) begin
				// hold new value; rebuild pool once cfg_we drops
				if (cfg_index == REG_TOTAL) tcfg_q <= cfg_data;
				else mcfg_q <= cfg_data;
				init_q <= 1'b1;
			end else if (init_q) begin
				init_q <= 1'b0;
				unit_q <= u_w; top_q <= top_w;
				for (int i = 0; i < Levels; i++)
					cnt_q[i] <= (OrdBits'(i) == top_w[OrdBits-1:0]) ? CntBits'(1) : '0;
				live_cnt_q <= '0; next_id_q <= '0;
			end
			// the init cycle in the idle state writes offset 0 into slot 0 of the top list
			case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					op_q <= op; req_q <= request_size; bid_q <= block_id;
					p_q <= '0; j_q <= '0; rd_pend_q <= 1'b0;
					status_q <= ST_OK; gid_q <= '0; addr_q <= '0; size_q <= '0;
					waste_q <= '0;
					if (op) state_q <= S_LSCAN;
					else if (request_size == '0) begin
						status_q <= ST_BAD_SIZE; state_q <= S_DONE;
					end else state_q <= S_SIZE;
				end
				S_SIZE: begin
					// advance one power per cycle
					if (p_q < 5'd25 && (25'd1 << p_q) < {1'b0, req_q}) p_q <= p_q + 1'b1;
					else begin
						if (((p_q < unit_q) ? unit_q : p_q) - unit_q > top_q) begin
							status_q <= ST_NO_MEM; state_q <= S_DONE;
						end else begin
							ord_q <= OrdBits'(((p_q < unit_q) ? unit_q : p_q) - unit_q);
							k_q <= OrdBits'(((p_q < unit_q) ? unit_q : p_q) - unit_q);
							state_q <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (cnt_q[k_q] != '0) begin
						rd_pend_q <= 1'b0; half_q <= 1'b0;
						state_q <= (k_q == ord_q) ? S_TAKE : S_SPLIT;
					end else if (k_q >= top_o) begin
						status_q <= ST_NO_MEM; state_q <= S_DONE;
					end else k_q <= k_q + 1'b1;
				end
				S_SPLIT: begin
					if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (!half_q) begin
						// upper half goes in next, from the PUSH state
						off_q <= fl_rd_q + (SlotBits'(1) << (k_q - 1'b1));
						if (cnt_q[k_q - 1'b1] != CntBits'(Slots))
							cnt_q[k_q - 1'b1] <= cnt_q[k_q - 1'b1] + 1'b1;
						half_q <= 1'b1;
						state_q <= S_PUSH; ord_q <= k_q - 1'b1;
						cnt_q[k_q] <= cnt_q[k_q] - 1'b1;
					end
				end
				S_PUSH: begin
					if (cnt_q[ord_q] != CntBits'(Slots)) cnt_q[ord_q] <= cnt_q[ord_q] + 1'b1;
					if (half_q) begin
						// upper half pushed; continue down
						half_q <= 1'b0; rd_pend_q <= 1'b0;
						k_q <= ord_q;
						ord_q <= OrdBits'(((p_q < unit_q) ? unit_q : p_q) - unit_q);
						state_q <= (ord_q == OrdBits'(((p_q < unit_q) ? unit_q : p_q) - unit_q))
							? S_TAKE : S_SPLIT;
					end else state_q <= S_DONE;
				end
				S_TAKE: begin
					if (cnt_q[ord_q] == '0 || live_cnt_q == CntBits'(Slots)) begin
						status_q <= ST_NO_MEM; state_q <= S_DONE;
					end else if (!rd_pend_q) rd_pend_q <= 1'b1;
					else begin
						cnt_q[ord_q] <= cnt_q[ord_q] - 1'b1;
						off_q <= fl_rd_q;
						gid_q <= next_id_q;
						addr_q <= 20'({fl_rd_q, 20'd0} >> (5'd20 - unit_q));
						size_q <= bsz[20:0];
						waste_q <= 20'(bsz - 26'(req_q));
						state_q <= S_DONE;
					end
				end
				S_LSCAN: begin
					if (j_q >= live_cnt_q) begin
						status_q <= ST_NO_ID; state_q <= S_DONE;
					end else if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (lt_id == bid_q) begin
						off_q <= lt_off; ord_q <= lt_ord;
						addr_q <= 20'({lt_off, 20'd0} >> (5'd20 - unit_q));
						size_q <= 21'((26'd1 << (5'(lt_ord) + unit_q)));
						rd_pend_q <= 1'b0; state_q <= S_LSHIFT;
					end else begin
						j_q <= j_q + 1'b1; rd_pend_q <= 1'b0;
					end
				end
				S_LSHIFT: begin
					if (j_q + 1'b1 >= live_cnt_q) begin
						live_cnt_q <= live_cnt_q - 1'b1;
						j_q <= '0; rd_pend_q <= 1'b0; state_q <= S_MSCAN;
					end else if (!rd_pend_q) rd_pend_q <= 1'b1;
					else begin
						j_q <= j_q + 1'b1; rd_pend_q <= 1'b0;
					end
				end
				S_MSCAN: begin
					if (ord_q >= top_o || j_q >= cnt_q[ord_q]) begin
						state_q <= S_PUSH; half_q <= 1'b0;
					end else if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (fl_rd_q == buddy) begin
						rd_pend_q <= 1'b0; state_q <= S_MSHIFT;
					end else begin
						j_q <= j_q + 1'b1; rd_pend_q <= 1'b0;
					end
				end
				S_MSHIFT: begin
					if (j_q + 1'b1 >= cnt_q[ord_q]) begin
						cnt_q[ord_q] <= cnt_q[ord_q] - 1'b1;
						if (buddy < off_q) off_q <= buddy;
						ord_q <= ord_q + 1'b1;
						j_q <= '0; rd_pend_q <= 1'b0; state_q <= S_MSCAN;
					end else if (!rd_pend_q) rd_pend_q <= 1'b1;
					else begin
						j_q <= j_q + 1'b1; rd_pend_q <= 1'b0;
					end
				end
				S_DONE: begin
					// hold here while the previous result still waits
					if (done_fire) begin
						if (status_q == ST_OK && !op_q) begin
							live_cnt_q <= live_cnt_q + 1'b1;
							next_id_q <= next_id_q + 1'b1;
						end
						res_status_q <= status_q; res_id_q <= gid_q; res_addr_q <= addr_q;
						res_size_q <= size_q; res_waste_q <= waste_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
